### hdl/selective_repeat_window_engine_assert.svh
// assertion macros for the selective repeat window engine
`ifndef SELECTIVE_REPEAT_WINDOW_ENGINE_ASSERT_SVH
`define SELECTIVE_REPEAT_WINDOW_ENGINE_ASSERT_SVH
// condition holds at every clock edge out of reset
`define SRWE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);
// condition in one cycle implies a condition in the next
`define SRWE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`endif

### hdl/srwe_pkg.sv
// types, codes and helpers of the selective repeat window engine
package srwe_pkg;
  localparam int SEQ_W = 3;
  localparam int PAY_W = 32;
  localparam int SEQ_COUNT = 8;
  localparam int SEND_WINDOW = 4;
  localparam int RECV_WINDOW = 4;

  localparam logic [2:0] FUNC_NEW = 3'd0;
  localparam logic [2:0] FUNC_FRAME = 3'd1;
  localparam logic [2:0] FUNC_DAMAGED = 3'd2;
  localparam logic [2:0] FUNC_RETX_TO = 3'd3;
  localparam logic [2:0] FUNC_ACK_TO = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_NAK = 2'd2;

  localparam logic [2:0] ACT_SEND = 3'd0;
  localparam logic [2:0] ACT_ACK = 3'd1;
  localparam logic [2:0] ACT_NAK = 3'd2;
  localparam logic [2:0] ACT_DELIVER = 3'd3;
  localparam logic [2:0] ACT_STOP = 3'd4;
  localparam logic [2:0] ACT_ACK_TIMER = 3'd5;
  localparam logic [2:0] ACT_STATUS = 3'd6;

  typedef struct packed {
    logic [2:0]       func;
    logic [PAY_W-1:0] outgoing_payload;
    logic [1:0]       frame_kind;
    logic [SEQ_W-1:0] frame_seq;
    logic [SEQ_W-1:0] frame_ack;
    logic [PAY_W-1:0] frame_payload;
    logic [SEQ_W-1:0] expired_seq;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [SEQ_W-1:0] seq_out;
    logic [SEQ_W-1:0] ack_out;
    logic [PAY_W-1:0] payload_out;
    logic             network_enable;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_NEW,
    CMD_RESEND_NAK,
    CMD_RX_DATA,
    CMD_DELIVER,
    CMD_SEND_ACK,
    CMD_SEND_NAK,
    CMD_RETX,
    CMD_STOP,
    CMD_STATUS
  } cmd_e;

  typedef struct packed {
    logic [2:0] func;
    logic [1:0] kind;
    logic       full;
    logic       nak_hit;
    logic       rx_ok;
    logic       rb_marked;
    logic       ack_hit;
    logic       lk_data;
  } dp_status_t;

  function automatic logic in_win(logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] a,
                                  logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] ds;
    logic [SEQ_W-1:0] db;
    ds = s - a;
    db = b - a;
    return ds < db;
  endfunction
endpackage

### hdl/selective_repeat_window_engine.sv
// top level of the selective repeat window engine
//  channel  | ports                     | accepted when
//  event    | start_i, item_i, busy_o   | start_i high and busy_o low
//  result   | valid_o, result_o         | every cycle valid_o is high
// an event holds the engine from its accept edge to the next accept for the
// accept cycle, a decode step that emits the first action if any, one step per
// further action and one empty step closing each delivery or stop loop
// each result item shows for one cycle, in the cycle after its step; the last is
// the status, and the receiver cannot stall; reset clears windows and marks
module selective_repeat_window_engine import srwe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  item_i,
  output logic      busy_o,
  output logic      valid_o,
  output out_item_t result_o
);
  cmd_e       cmd;
  dp_status_t sts;

  srwe_controller u_ctrl (
    .clk_i, .rst_ni, .start_i, .sts_i(sts), .cmd_o(cmd), .busy_o
  );

  srwe_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i, .sts_o(sts), .valid_o, .result_o
  );
endmodule

### hdl/srwe_datapath.sv
// window state, stores and result register of the engine
module srwe_datapath import srwe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_e       cmd_i,
  input  in_item_t   item_i,
  output dp_status_t sts_o,
  output logic       valid_o,
  output out_item_t  result_o
);
  logic [SEQ_W-1:0] sb_q, ns_q, rb_q;
  logic [2:0]       cnt_q;
  logic [SEQ_COUNT-1:0] marks_q;
  logic [1:0]       lk_q;
  logic             valid_q, valid_d;
  in_item_t         item_q;
  out_item_t        res_q, res_d;
  logic [PAY_W-1:0] send_mem [SEQ_COUNT];
  logic [PAY_W-1:0] recv_mem [SEQ_COUNT];
  logic [SEQ_W-1:0] fack_m1, rx_off;

  assign fack_m1 = item_q.frame_ack - 1'b1;
  assign rx_off = item_q.frame_seq - rb_q;

  always_comb begin
    sts_o.func = item_q.func;
    sts_o.kind = item_q.frame_kind;
    sts_o.full = cnt_q >= 3'(SEND_WINDOW);
    sts_o.nak_hit = in_win(item_q.frame_ack, sb_q, ns_q);
    sts_o.rx_ok = (rx_off < SEQ_W'(RECV_WINDOW)) && !marks_q[item_q.frame_seq];
    sts_o.rb_marked = marks_q[rb_q];
    sts_o.ack_hit = in_win(fack_m1, sb_q, ns_q);
    sts_o.lk_data = lk_q == KIND_DATA;
  end

  always_comb begin
    res_d = '0;
    valid_d = 1'b1;
    case (cmd_i)
      CMD_NEW: begin
        res_d.action = ACT_SEND;
        res_d.seq_out = ns_q;
        res_d.ack_out = rb_q;
        res_d.payload_out = item_q.outgoing_payload;
      end
      CMD_RESEND_NAK: begin
        res_d.action = ACT_SEND;
        res_d.seq_out = item_q.frame_ack;
        res_d.ack_out = rb_q;
        res_d.payload_out = send_mem[item_q.frame_ack];
      end
      CMD_RETX: begin
        res_d.action = ACT_SEND;
        res_d.seq_out = item_q.expired_seq;
        res_d.ack_out = rb_q;
        res_d.payload_out = send_mem[item_q.expired_seq];
      end
      CMD_RX_DATA: res_d.action = ACT_ACK_TIMER;
      CMD_DELIVER: begin
        res_d.action = ACT_DELIVER;
        res_d.payload_out = recv_mem[rb_q];
      end
      CMD_SEND_ACK: begin
        res_d.action = ACT_ACK;
        res_d.ack_out = rb_q;
      end
      CMD_SEND_NAK: begin
        res_d.action = ACT_NAK;
        res_d.ack_out = rb_q;
      end
      CMD_STOP: begin
        res_d.action = ACT_STOP;
        res_d.seq_out = sb_q;
      end
      CMD_STATUS: begin
        res_d.action = ACT_STATUS;
        res_d.network_enable = cnt_q < 3'(SEND_WINDOW);
        res_d.last = 1'b1;
      end
      default: valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q <= '0;
      ns_q <= '0;
      rb_q <= '0;
      cnt_q <= '0;
      marks_q <= '0;
      lk_q <= KIND_ACK;
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      case (cmd_i)
        CMD_LATCH: if (item_i.func == FUNC_FRAME) lk_q <= item_i.frame_kind;
        CMD_NEW: begin
          ns_q <= ns_q + 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end
        CMD_RX_DATA: if (sts_o.rx_ok) marks_q[item_q.frame_seq] <= 1'b1;
        CMD_DELIVER: begin
          marks_q[rb_q] <= 1'b0;
          rb_q <= rb_q + 1'b1;
        end
        CMD_STOP: begin
          sb_q <= sb_q + 1'b1;
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i == CMD_LATCH) item_q <= item_i;
    if (cmd_i == CMD_NEW) send_mem[ns_q] <= item_q.outgoing_payload;
    if (cmd_i == CMD_RX_DATA && sts_o.rx_ok) recv_mem[item_q.frame_seq] <= item_q.frame_payload;
  end

  assign valid_o = valid_q;
  assign result_o = res_q;

  `include "selective_repeat_window_engine_assert.svh"
  `SRWE_ASSERT_ALWAYS(a_cnt_max, cnt_q <= 3'(SEND_WINDOW), "outstanding count over window")
  `SRWE_ASSERT_ALWAYS(a_cnt_span, cnt_q == 3'(ns_q - sb_q), "count disagrees with window span")
  `SRWE_ASSERT_NEXT(a_gap, valid_q && res_q.last, !valid_q, "item right after status")
endmodule

### hdl/srwe_controller.sv
// sequencer that steps one event through its run of actions
module srwe_controller import srwe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t sts_i,
  output cmd_e       cmd_o,
  output logic       busy_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_FIRST, ST_DELIVER, ST_NAK2, ST_ACK, ST_STATUS
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o = CMD_NONE;
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) begin
        cmd_o = CMD_LATCH;
        state_d = ST_FIRST;
      end
      ST_FIRST: begin
        state_d = ST_STATUS;
        case (sts_i.func)
          FUNC_NEW: if (!sts_i.full) cmd_o = CMD_NEW;
          FUNC_FRAME: begin
            state_d = ST_ACK;
            if (sts_i.kind == KIND_NAK && sts_i.nak_hit) begin
              cmd_o = CMD_RESEND_NAK;
            end else if (sts_i.kind == KIND_DATA) begin
              cmd_o = CMD_RX_DATA;
              state_d = ST_DELIVER;
            end
          end
          FUNC_DAMAGED: if (sts_i.lk_data) begin
            cmd_o = CMD_SEND_ACK;
            state_d = ST_NAK2;
          end
          FUNC_RETX_TO: cmd_o = CMD_RETX;
          FUNC_ACK_TO: cmd_o = CMD_SEND_ACK;
          default: ;
        endcase
      end
      ST_DELIVER: begin
        if (sts_i.rb_marked) cmd_o = CMD_DELIVER;
        else state_d = ST_ACK;
      end
      ST_NAK2: begin
        cmd_o = CMD_SEND_NAK;
        state_d = ST_STATUS;
      end
      ST_ACK: begin
        if (sts_i.ack_hit) cmd_o = CMD_STOP;
        else state_d = ST_STATUS;
      end
      ST_STATUS: begin
        cmd_o = CMD_STATUS;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q <= state_d != ST_IDLE;
    end
  end

  assign busy_o = busy_q;
endmodule

### bench/selective_repeat_window_engine_checker.sv
// link event predictor and result checker for the selective repeat window engine
`timescale 1ns / 1ps
module selective_repeat_window_engine_checker import srwe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  item_i,
  input  logic      busy_i,
  input  logic      valid_i,
  input  out_item_t result_i,
  output int        fail_count_o,
  output int        pending_o
);
  logic [SEQ_W-1:0] send_base, next_send, recv_base;
  int unsigned      outstanding;
  logic [PAY_W-1:0] send_copy [SEQ_COUNT];
  logic [PAY_W-1:0] recv_copy [SEQ_COUNT];
  logic             arrived [SEQ_COUNT];
  logic [1:0]       last_kind;
  out_item_t        expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic within_win(logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] a,
                                      logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] ds;
    logic [SEQ_W-1:0] db;
    ds = s - a;
    db = b - a;
    return ds < db;
  endfunction

  task automatic push_action(logic [2:0] act, logic [SEQ_W-1:0] sq, logic [SEQ_W-1:0] ak,
                             logic [PAY_W-1:0] pay, logic en, logic fin);
    out_item_t r;
    r.action = act;
    r.seq_out = sq;
    r.ack_out = ak;
    r.payload_out = pay;
    r.network_enable = en;
    r.last = fin;
    expected_q.push_back(r);
  endtask

  task automatic predict_event(in_item_t ev);
    logic [SEQ_W-1:0] rwin_end;
    logic [SEQ_W-1:0] ack_prev;
    case (ev.func)
      FUNC_NEW: begin
        if (outstanding < SEND_WINDOW) begin
          send_copy[next_send] = ev.outgoing_payload;
          push_action(ACT_SEND, next_send, recv_base, ev.outgoing_payload, 1'b0, 1'b0);
          outstanding++;
          next_send = next_send + 1'b1;
        end
      end
      FUNC_FRAME: begin
        last_kind = ev.frame_kind;
        if (ev.frame_kind == KIND_NAK && within_win(ev.frame_ack, send_base, next_send)) begin
          push_action(ACT_SEND, ev.frame_ack, recv_base, send_copy[ev.frame_ack], 1'b0, 1'b0);
        end else if (ev.frame_kind == KIND_DATA) begin
          push_action(ACT_ACK_TIMER, '0, '0, '0, 1'b0, 1'b0);
          rwin_end = recv_base + SEQ_W'(RECV_WINDOW);
          if (within_win(ev.frame_seq, recv_base, rwin_end) && !arrived[ev.frame_seq]) begin
            arrived[ev.frame_seq] = 1'b1;
            recv_copy[ev.frame_seq] = ev.frame_payload;
            while (arrived[recv_base]) begin
              push_action(ACT_DELIVER, '0, '0, recv_copy[recv_base], 1'b0, 1'b0);
              arrived[recv_base] = 1'b0;
              recv_base = recv_base + 1'b1;
            end
          end
        end
        ack_prev = ev.frame_ack - 1'b1;
        while (within_win(ack_prev, send_base, next_send)) begin
          if (outstanding > 0) outstanding--;
          push_action(ACT_STOP, send_base, '0, '0, 1'b0, 1'b0);
          send_base = send_base + 1'b1;
        end
      end
      FUNC_DAMAGED: begin
        if (last_kind == KIND_DATA) begin
          push_action(ACT_ACK, '0, recv_base, '0, 1'b0, 1'b0);
          push_action(ACT_NAK, '0, recv_base, '0, 1'b0, 1'b0);
        end
      end
      FUNC_RETX_TO: begin
        push_action(ACT_SEND, ev.expired_seq, recv_base, send_copy[ev.expired_seq],
                    1'b0, 1'b0);
      end
      FUNC_ACK_TO: begin
        push_action(ACT_ACK, '0, recv_base, '0, 1'b0, 1'b0);
      end
      default: begin
      end
    endcase
    push_action(ACT_STATUS, '0, '0, '0, outstanding < SEND_WINDOW, 1'b1);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      send_base = '0;
      next_send = '0;
      recv_base = '0;
      outstanding = 0;
      last_kind = KIND_ACK;
      for (int i = 0; i < SEQ_COUNT; i++) begin
        send_copy[i] = '0;
        recv_copy[i] = '0;
        arrived[i] = 1'b0;
      end
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: action %0d", result_i.action);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (result_i.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, result_i.action);
            fail_count_o++;
          end
          if (result_i.seq_out !== want.seq_out) begin
            $error("seq_out: expected %0d, actual %0d", want.seq_out, result_i.seq_out);
            fail_count_o++;
          end
          if (result_i.ack_out !== want.ack_out) begin
            $error("ack_out: expected %0d, actual %0d", want.ack_out, result_i.ack_out);
            fail_count_o++;
          end
          if (result_i.payload_out !== want.payload_out) begin
            $error("payload_out: expected %h, actual %h", want.payload_out,
                   result_i.payload_out);
            fail_count_o++;
          end
          if (result_i.network_enable !== want.network_enable) begin
            $error("network_enable: expected %0d, actual %0d", want.network_enable,
                   result_i.network_enable);
            fail_count_o++;
          end
          if (result_i.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, result_i.last);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) predict_event(item_i);
    end
  end
endmodule

### bench/selective_repeat_window_engine_tb.sv
// stimulus and verdict for the selective repeat window engine
`timescale 1ns / 1ps
module selective_repeat_window_engine_tb import srwe_pkg::*;;
  localparam int QUIET_LIMIT = 2000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  in_item_t  item_i = '0;
  logic      busy_o;
  logic      valid_o;
  out_item_t result_o;
  int        fail_count;
  int        pending;
  int        quiet_cycles = 0;
  logic [SEQ_W-1:0] sent_mask_next = '0;
  logic [SEQ_COUNT-1:0] written;

  always #5 clk_i = ~clk_i;

  selective_repeat_window_engine DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_o(busy_o), .valid_o(valid_o), .result_o(result_o)
  );

  selective_repeat_window_engine_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .item_i(item_i),
    .busy_i(busy_o), .valid_i(valid_o), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sends one item; written tracks send slots so a retransmit never hits a blank one
  task automatic send_item(in_item_t ev, bit gaps);
    if (ev.func == FUNC_RETX_TO && !written[ev.expired_seq]) ev.func = FUNC_ACK_TO;
    while (gaps && $urandom_range(99) < 26) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= ev;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // a send slot counts as written once its send result item is seen
  always @(posedge clk_i) begin
    if (valid_o && result_o.action == ACT_SEND) written[result_o.seq_out] <= 1'b1;
  end

  function automatic in_item_t rand_item(logic [2:0] fn);
    in_item_t ev;
    ev.func = fn;
    ev.outgoing_payload = $urandom;
    ev.frame_kind = 2'($urandom_range(3));
    ev.frame_seq = 3'($urandom_range(7));
    ev.frame_ack = 3'($urandom_range(7));
    ev.frame_payload = $urandom;
    ev.expired_seq = 3'($urandom_range(7));
    return ev;
  endfunction

  task automatic drain;
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (15) @(posedge clk_i);
  endtask

  initial begin
    in_item_t ev;
    logic [SEQ_W-1:0] tx_next;
    logic [SEQ_W-1:0] rx_next;
    int roll;
    written = '0;
    tx_next = '0;
    rx_next = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: damaged before any data, then fill and overfill the window
    ev = rand_item(FUNC_DAMAGED);
    send_item(ev, 0);
    ev = rand_item(FUNC_ACK_TO);
    send_item(ev, 0);
    for (int i = 0; i < 5; i++) begin
      ev = rand_item(FUNC_NEW);
      ev.outgoing_payload = (i == 0) ? '0 : (i == 1) ? '1 : $urandom;
      sent_mask_next = tx_next;
      send_item(ev, 0);
      if (i < 4) tx_next = tx_next + 1'b1;
    end
    ev = rand_item(FUNC_RETX_TO);
    ev.expired_seq = 3'd2;
    send_item(ev, 0);
    ev = rand_item(FUNC_FRAME);
    ev.frame_kind = KIND_NAK;
    ev.frame_ack = 3'd1;
    send_item(ev, 0);
    // out-of-order data, then the gap filled
    for (int i = 0; i < 4; i++) begin
      ev = rand_item(FUNC_FRAME);
      ev.frame_kind = KIND_DATA;
      ev.frame_seq = (i == 3) ? 3'd0 : 3'(3 - i);
      ev.frame_ack = 3'd0;
      ev.frame_payload = (i == 0) ? '1 : (i == 1) ? '0 : $urandom;
      send_item(ev, 0);
    end
    rx_next = 3'd4;
    ev = rand_item(FUNC_DAMAGED);
    send_item(ev, 0);
    ev = rand_item(FUNC_FRAME);
    ev.frame_kind = 2'd3;
    ev.frame_ack = 3'd7;
    send_item(ev, 0);
    ev = rand_item(FUNC_FRAME);
    ev.frame_kind = KIND_ACK;
    ev.frame_ack = 3'd4;
    send_item(ev, 0);
    for (int f = 5; f < 8; f++) begin
      ev = rand_item(3'(f));
      send_item(ev, 0);
    end
    ev = rand_item(FUNC_DAMAGED);
    send_item(ev, 0);
    drain();

    // random: mostly well-formed traffic, some noise
    for (int n = 0; n < 310; n++) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        ev = rand_item(FUNC_NEW);
        sent_mask_next = tx_next;
      end else if (roll < 70) begin
        ev = rand_item(FUNC_FRAME);
        ev.frame_kind = ($urandom_range(9) < 6) ? KIND_DATA : 2'($urandom_range(3));
        if ($urandom_range(3) != 0) ev.frame_seq = 3'(rx_next + $urandom_range(3));
        if ($urandom_range(3) != 0) ev.frame_ack = 3'(tx_next - $urandom_range(3));
      end else if (roll < 80) begin
        ev = rand_item(FUNC_DAMAGED);
      end else if (roll < 88) begin
        ev = rand_item(FUNC_RETX_TO);
      end else if (roll < 96) begin
        ev = rand_item(FUNC_ACK_TO);
      end else begin
        ev = rand_item(3'($urandom_range(5, 7)));
      end
      send_item(ev, !(n >= 100 && n < 160));
      if (ev.func == FUNC_NEW) tx_next = sent_mask_next + 1'b1;
      if (n == 200) drain();
    end

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/srwe_pkg.sv
hdl/srwe_datapath.sv
hdl/srwe_controller.sv
hdl/selective_repeat_window_engine.sv
bench/selective_repeat_window_engine_checker.sv
bench/selective_repeat_window_engine_tb.sv
